/* rtl/wfra_pkg.sv */
// Shared constants and types for the weighted FIFO resource allocator.
// No dependencies; imported by weighted_fifo_resource_allocator.
package wfra_pkg;

    // Queue and identity sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int MAX_RESULTS = 16;

    // Fixed field widths of the request and result channels
    localparam int REQ_ID_W  = 8;
    localparam int UNIT_W    = 16;
    localparam int TDATA_W   = REQ_ID_W + UNIT_W;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int ID_KEEP_W = (ID_WIDTH < REQ_ID_W) ? ID_WIDTH : REQ_ID_W;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WAKE_W    = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W   = UNIT_W + ID_KEEP_W;

    // Request kinds carried on s_tuser
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    // Result kinds carried on m_tuser
    typedef enum logic [1:0] {
        RK_GRANT  = 2'd0,
        RK_QUEUED = 2'd1,
        RK_WOKEN  = 2'd2,
        RK_REJECT = 2'd3
    } result_kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_MAX = 2'd1;

endpackage

/* rtl/weighted_fifo_resource_allocator.sv */
// Weighted FIFO counting allocator: free counter, waiter queue and sequencer.
// Depends on wfra_pkg for widths, request and result kinds and register indexes.
//
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       tuser: req_type; tdata: requester_id, amount
// m_       out        m_tvalid / m_tready       tuser: result_kind; tdata: who, granted_amount;
//                                               tlast: last
// cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An allocate request passes through accept, clamp, then decide and load the result register.
// A free request passes through accept and add, then wake rounds: the single subtract/compare unit checks
// the head waiter once per round, and each round waits in a read-wait state for the queue memory read.
// Reset (aresetn low, synchronous) empties the queue and clears the free counter to zero.
// Stalls on m_tready hold the sequencer only when a result must be loaded into a full output
// register; s_tready is high only while the sequencer is idle. cfg_ready is always high.
module weighted_fifo_resource_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wfra_pkg::TDATA_W-1:0]   s_tdata,   // [7:0] requester_id, [23:8] amount
    input  logic                           s_tuser,   // [0] req_type
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wfra_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] who, [23:8] granted_amount
    output logic [1:0]                     m_tuser,   // [1:0] result_kind
    output logic                           m_tlast,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wfra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wfra_pkg::UNIT_W-1:0]    cfg_data
);
    import wfra_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_ALLOC,
        ST_ADD,
        ST_WAKE,
        ST_RDWAIT
    } state_t;

    state_t                 state_reg;
    logic [ID_KEEP_W-1:0]   id_reg;
    logic [UNIT_W-1:0]      amt_reg;
    logic [UNIT_W-1:0]      free_reg;
    logic [UNIT_W-1:0]      request_max_reg;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       tail_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [WAKE_W-1:0]      wake_cnt_reg;

    // Waiter queue memory, read at the head every cycle
    logic [ENTRY_W-1:0]     waiter_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;

    // Held wake result, sent once it is known whether another follows
    logic                   pend_valid_reg;
    logic [ID_KEEP_W-1:0]   pend_id_reg;
    logic [UNIT_W-1:0]      pend_amt_reg;

    // Output register
    logic                   m_valid_reg;
    result_kind_t           m_kind_reg;
    logic [REQ_ID_W-1:0]    m_who_reg;
    logic [UNIT_W-1:0]      m_amt_reg;
    logic                   m_last_reg;

    logic [UNIT_W-1:0]      unit_a;
    logic [UNIT_W-1:0]      unit_b;
    logic [UNIT_W:0]        unit_res;
    logic                   unit_borrow;
    logic [UNIT_W-1:0]      unit_diff;
    logic [UNIT_W:0]        sum_wide;
    logic [UNIT_W-1:0]      free_next;
    logic [UNIT_W-1:0]      rd_amt;
    logic [ID_KEEP_W-1:0]   rd_id;
    logic                   out_free;
    logic                   wake_fit;
    logic [PTR_W-1:0]       head_next;
    logic [PTR_W-1:0]       tail_next;

    // Shared subtract/compare unit: operands chosen by the sequencer state
    always_comb begin
        case (state_reg)
            ST_CLAMP: begin
                unit_a = amt_reg;
                unit_b = request_max_reg;
            end
            ST_ALLOC: begin
                unit_a = free_reg;
                unit_b = amt_reg;
            end
            default: begin
                unit_a = free_reg;
                unit_b = rd_amt;
            end
        endcase
        unit_res    = {1'b0, unit_a} - {1'b0, unit_b};
        unit_borrow = unit_res[UNIT_W];
        unit_diff   = unit_res[UNIT_W-1:0];
    end

    // Saturating return of units
    assign sum_wide  = {1'b0, free_reg} + {1'b0, amt_reg};
    assign free_next = sum_wide[UNIT_W] ? {UNIT_W{1'b1}} : sum_wide[UNIT_W-1:0];

    // Queue pointer wrap and head entry fields
    assign head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign rd_amt    = rd_data_reg[ENTRY_W-1:ID_KEEP_W];
    assign rd_id     = rd_data_reg[ID_KEEP_W-1:0];

    assign out_free = !m_valid_reg || m_tready;
    assign wake_fit = (count_reg != '0) && !unit_borrow
                      && (wake_cnt_reg != WAKE_W'(MAX_RESULTS));

    // Queue memory: written on enqueue, head entry read every cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ALLOC && out_free && count_reg < CNT_W'(QUEUE_DEPTH)
            && !(count_reg == '0 && !unit_borrow)) begin
            waiter_mem[tail_reg] <= {amt_reg, id_reg};
        end
        rd_data_reg <= waiter_mem[head_reg];
    end

    // Sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            free_reg        <= '0;
            request_max_reg <= {UNIT_W{1'b1}};
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            wake_cnt_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // Configuration writes are to arrive only while idle; the block itself does not enforce this
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POOL_TOTAL:  free_reg <= cfg_data;
                    CFG_REQUEST_MAX: request_max_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        id_reg    <= s_tdata[ID_KEEP_W-1:0];
                        amt_reg   <= s_tdata[TDATA_W-1:REQ_ID_W];
                        state_reg <= (req_type_t'(s_tuser) == REQ_ALLOC) ? ST_CLAMP : ST_ADD;
                    end
                end
                ST_CLAMP: begin
                    if (!unit_borrow) begin
                        amt_reg <= request_max_reg;
                    end
                    state_reg <= ST_ALLOC;
                end
                ST_ALLOC: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_who_reg   <= REQ_ID_W'(id_reg);
                        m_amt_reg   <= amt_reg;
                        m_last_reg  <= 1'b1;
                        if (count_reg == '0 && !unit_borrow) begin
                            free_reg   <= unit_diff;
                            m_kind_reg <= RK_GRANT;
                        end else if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                            tail_reg   <= tail_next;
                            count_reg  <= count_reg + 1'b1;
                            m_kind_reg <= RK_QUEUED;
                        end else begin
                            m_kind_reg <= RK_REJECT;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ADD: begin
                    free_reg     <= free_next;
                    wake_cnt_reg <= '0;
                    state_reg    <= ST_WAKE;
                end
                ST_WAKE: begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= RK_WOKEN;
                            m_who_reg   <= REQ_ID_W'(pend_id_reg);
                            m_amt_reg   <= pend_amt_reg;
                            m_last_reg  <= !wake_fit;
                        end
                        if (wake_fit) begin
                            free_reg       <= unit_diff;
                            head_reg       <= head_next;
                            count_reg      <= count_reg - 1'b1;
                            wake_cnt_reg   <= wake_cnt_reg + 1'b1;
                            pend_valid_reg <= 1'b1;
                            pend_id_reg    <= rd_id;
                            pend_amt_reg   <= rd_amt;
                            state_reg      <= ST_RDWAIT;
                        end else begin
                            pend_valid_reg <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end
                ST_RDWAIT: begin
                    state_reg <= ST_WAKE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_amt_reg, m_who_reg};
    assign m_tuser   = m_kind_reg;
    assign m_tlast   = m_last_reg;

    // The waiter count never passes the queue depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("waiter count above queue depth");

    // A free never wakes more than the result limit.
    a_wake_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wake_cnt_reg <= WAKE_W'(MAX_RESULTS))
        else $error("too many waiters woken by one free");

    // A held wake result exists only while waking.
    a_pend_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_WAKE || state_reg == ST_RDWAIT))
        else $error("held wake result outside the wake loop");

    // Deciding an allocate always presents one final result.
    a_alloc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC && out_free) |=> (m_valid_reg && m_last_reg))
        else $error("allocate decision produced no final result");

    // Each wake removes exactly one waiter.
    a_wake_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAKE && wake_fit && (!pend_valid_reg || out_free))
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("wake did not remove one waiter");

endmodule

/* test/weighted_fifo_resource_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for weighted_fifo_resource_allocator: directed and random requests
// with a built-in allocator predictor. Depends on wfra_pkg and the allocator RTL only.
module weighted_fifo_resource_allocator_test;
    import wfra_pkg::*;

    // Spare register indexes, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int RANDOM_ITEMS  = 360;
    // Allowance for a free and all its wakes to finish before the block is idle again
    localparam int SETTLE_CYCLES = 3 + 2 * MAX_RESULTS + 16;
    localparam longint RUN_LIMIT_NS = 64'd6_000_000;
    localparam logic [REQ_ID_W-1:0] ID_KEEP_MASK = REQ_ID_W'((1 << ID_KEEP_W) - 1);

    typedef struct {
        logic [REQ_ID_W-1:0] id;
        logic [UNIT_W-1:0]   amount;
    } waiter_t;

    typedef struct {
        result_kind_t        kind;
        logic [REQ_ID_W-1:0] who;
        logic [UNIT_W-1:0]   amount;
        logic                last;
    } outcome_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [UNIT_W-1:0]    cfg_data  = '0;

    // Predictor state: the pool, its registers and the waiter line
    logic [UNIT_W-1:0] units_free  = '0;
    logic [UNIT_W-1:0] request_cap = '1;
    waiter_t           waiter_line[$];
    outcome_t          pending_results[$];

    int error_count = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;

    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_pos   = 0;

    weighted_fifo_resource_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls follow a 16-bit ready pattern that is redrawn each time it runs out.
    always @(negedge aclk) begin
        if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'h00FF;
            endcase
        end
        m_tready <= ready_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 16;
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic outcome_t make_outcome(input result_kind_t kind,
                                              input logic [REQ_ID_W-1:0] who,
                                              input logic [UNIT_W-1:0] amount,
                                              input logic last);
        outcome_t o;
        o.kind   = kind;
        o.who    = who;
        o.amount = amount;
        o.last   = last;
        return o;
    endfunction

    function automatic bit head_waiter_fits();
        return waiter_line.size() > 0 && waiter_line[0].amount <= units_free;
    endfunction

    // Work out the results that one accepted request causes and queue them.
    task automatic predict_outcome(input req_type_t kind, input logic [REQ_ID_W-1:0] raw_id,
                                   input logic [UNIT_W-1:0] amount);
        logic [REQ_ID_W-1:0] id;
        logic [UNIT_W-1:0]   want;
        logic [UNIT_W:0]     sum;
        waiter_t             w;
        int                  woken;
        id = raw_id & ID_KEEP_MASK;
        if (kind == REQ_ALLOC) begin
            want = (amount < request_cap) ? amount : request_cap;
            if (waiter_line.size() == 0 && units_free >= want) begin
                units_free = units_free - want;
                pending_results.push_back(make_outcome(RK_GRANT, id, want, 1'b1));
            end else if (waiter_line.size() < QUEUE_DEPTH) begin
                w.id = id;
                w.amount = want;
                waiter_line.push_back(w);
                pending_results.push_back(make_outcome(RK_QUEUED, id, want, 1'b1));
            end else begin
                pending_results.push_back(make_outcome(RK_REJECT, id, want, 1'b1));
            end
        end else begin
            // Returned units saturate, then waiters are granted in order while the head fits.
            sum = {1'b0, units_free} + {1'b0, amount};
            units_free = sum[UNIT_W] ? '1 : sum[UNIT_W-1:0];
            woken = 0;
            while (woken < MAX_RESULTS && head_waiter_fits()) begin
                w = waiter_line.pop_front();
                units_free = units_free - w.amount;
                woken++;
                pending_results.push_back(make_outcome(RK_WOKEN, w.id, w.amount,
                    !(woken < MAX_RESULTS && head_waiter_fits())));
            end
        end
    endtask

    // Check every result the block hands over against the oldest expectation.
    always @(posedge aclk) begin : check_results
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result kind %0d who %0d amount %0d last %0b",
                    m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.who ||
                        m_tdata[23:8] !== want.amount || m_tlast !== want.last) begin
                    note_error($sformatf(
                        "expected kind %0d who %0d amount %0d last %0b, got %0d %0d %0d %0b",
                        want.kind, want.who, want.amount, want.last,
                        m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast));
                end
            end
        end
    end

    // Offer one request, wait for it to be taken, then follow the burst and gap schedule.
    task automatic send_request(input req_type_t kind, input logic [REQ_ID_W-1:0] id,
                                input logic [UNIT_W-1:0] amount);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {amount, id};
        do @(posedge aclk); while (!s_tready);
        predict_outcome(kind, id, amount);
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Stop sending and wait until every expected result is in and the block has settled.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [UNIT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_POOL_TOTAL) begin
            units_free = value;
        end else if (index == CFG_REQUEST_MAX) begin
            request_cap = value;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset values: empty pool, no clamp; zero grant, full-size wait and wake.
    task automatic test_reset_state();
        send_request(REQ_ALLOC, 8'h00, 16'h0000);
        send_request(REQ_ALLOC, 8'hFF, 16'hFFFF);
        send_request(REQ_FREE, 8'hAA, 16'hFFFF);
    endtask

    // Clamping by request_max, including a zero cap, and writes to spare indexes.
    task automatic test_clamp();
        wait_for_drain();
        write_register(CFG_REQUEST_MAX, 16'd100);
        write_register(CFG_SPARE_3, 16'h0000);
        write_register(CFG_POOL_TOTAL, 16'd1000);
        send_request(REQ_ALLOC, 8'h12, 16'hFFFF);
        send_request(REQ_ALLOC, 8'h34, 16'd99);
        wait_for_drain();
        write_register(CFG_SPARE_2, 16'hFFFF);
        write_register(CFG_REQUEST_MAX, 16'd0);
        send_request(REQ_ALLOC, 8'h56, 16'd500);
        wait_for_drain();
        write_register(CFG_REQUEST_MAX, 16'hFFFF);
    endtask

    // Fill the line (a zero-unit request waits behind others), overflow it, reload the pool
    // without waking anyone, then let a zero free wake the whole line at once.
    task automatic test_full_line();
        wait_for_drain();
        write_register(CFG_POOL_TOTAL, 16'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_request(REQ_ALLOC, 8'(i * 17 + 3), (i == 1) ? 16'd0 : 16'(i * 64 + 5));
        end
        send_request(REQ_ALLOC, 8'h5A, 16'd7);
        wait_for_drain();
        write_register(CFG_POOL_TOTAL, 16'hFFFF);
        send_request(REQ_FREE, 8'hC3, 16'd0);
    endtask

    // Frees saturate the counter; a full-size grant shows the pool stopped at the top.
    task automatic test_saturation();
        wait_for_drain();
        send_request(REQ_FREE, 8'h01, 16'hFFFF);
        send_request(REQ_ALLOC, 8'h80, 16'hFFFF);
        send_request(REQ_ALLOC, 8'h7F, 16'd1);
        send_request(REQ_FREE, 8'h02, 16'h8000);
    endtask

    // Phases of random traffic, each with its own pool, cap and amount range.
    task automatic test_random_traffic();
        int                  sent;
        int                  phase_len;
        int                  span;
        int                  pick;
        logic [UNIT_W-1:0]   pool;
        logic [UNIT_W-1:0]   cap;
        logic [UNIT_W-1:0]   amount;
        req_type_t           kind;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_for_drain();
            case ($urandom_range(0, 5))
                0: pool = 16'd0;
                1: pool = 16'hFFFF;
                2: pool = 16'($urandom_range(1, 15));
                3: pool = 16'($urandom_range(16, 255));
                4: pool = 16'($urandom_range(256, 4095));
                default: pool = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: cap = 16'd0;
                1: cap = 16'($urandom);
                2: cap = 16'($urandom_range(1, 255));
                default: cap = 16'hFFFF;
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(CFG_POOL_TOTAL, pool);
                write_register(CFG_REQUEST_MAX, cap);
            end else begin
                write_register(CFG_REQUEST_MAX, cap);
                write_register(CFG_POOL_TOTAL, pool);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               16'($urandom));
            end
            case ($urandom_range(0, 3))
                0: span = 15;
                1: span = 255;
                2: span = 4095;
                default: span = 65535;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(15, 45);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                kind = ($urandom_range(0, 99) < 55) ? REQ_ALLOC : REQ_FREE;
                pick = $urandom_range(0, 15);
                if (kind == REQ_ALLOC) begin
                    amount = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom)
                           : 16'($urandom_range(1, span));
                end else begin
                    amount = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0
                           : (pick == 2) ? 16'($urandom) : 16'($urandom_range(1, span));
                end
                send_request(kind, 8'($urandom), amount);
                sent++;
                // Now and then hold off until the block has delivered everything.
                if ($urandom_range(0, 24) == 0) begin
                    wait_for_drain();
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_clamp();
        test_full_line();
        test_saturation();
        test_random_traffic();
        wait_for_drain();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS weighted_fifo_resource_allocator");
        end else begin
            $display("FAIL weighted_fifo_resource_allocator");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL weighted_fifo_resource_allocator");
        $finish;
    end

endmodule

/* weighted_fifo_resource_allocator.f */
rtl/wfra_pkg.sv
rtl/weighted_fifo_resource_allocator.sv
test/weighted_fifo_resource_allocator_test.sv
